>>> hw/rtl/byte_ring_fifo_line_reader_defines.svh
// ----------------------------------------------------------------------------
// byte ring fifo line reader: assertion macros
// shared check wrappers for the line reader blocks
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_LINE_READER_DEFINES_SVH
`define BYTE_RING_FIFO_LINE_READER_DEFINES_SVH

// property that must hold at every edge out of reset
`define BRF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define BRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// types and constants shared by the line reader cells and top level
// ----------------------------------------------------------------------------
package brf_pkg;

	localparam int DATA_W = 8;
	localparam int REQ_W = 8;
	localparam int DEPTH_DEFAULT = 64;

	localparam logic [DATA_W-1:0] TERM_RESET = 8'd10;

	// action codes
	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_LINE  = 2'd2;
	localparam logic [1:0] ACT_FLUSH = 2'd3;

	// register index
	localparam logic REG_TERM = 1'b0;

	// broadcast control to every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
		logic flush;
		logic scan_start;
		logic scan_step;
	} cell_ctrl_t;

endpackage

>>> hw/rtl/brf_cell.sv
// ----------------------------------------------------------------------------
// brf_cell
// one byte slot of the fifo chain with its scan token
// ----------------------------------------------------------------------------
module brf_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  brf_pkg::cell_ctrl_t          ctrl,
	input  logic [brf_pkg::DATA_W-1:0]   byte_in,
	input  logic [brf_pkg::DATA_W-1:0]   term,
	input  logic                         head,
	input  logic                         prev_valid,
	input  logic                         prev_token,
	input  logic                         next_valid,
	input  logic [brf_pkg::DATA_W-1:0]   next_data,
	output logic                         valid,
	output logic                         token,
	output logic                         hit,
	output logic [brf_pkg::DATA_W-1:0]   data
);

	logic                       valid_q;
	logic                       token_q;
	logic [brf_pkg::DATA_W-1:0] data_q;
	logic                       fill;

	// first empty slot takes the pushed byte
	assign fill = ctrl.push & ~valid_q & prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			token_q <= 1'b0;
		end else begin
			if (ctrl.flush) begin
				valid_q <= 1'b0;
			end else if (ctrl.pop) begin
				valid_q <= next_valid;
			end else if (fill) begin
				valid_q <= 1'b1;
			end
			if (ctrl.scan_start) begin
				token_q <= head;
			end else if (ctrl.scan_step) begin
				token_q <= prev_token;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			data_q <= next_data;
		end else if (fill) begin
			data_q <= byte_in;
		end
	end

	assign valid = valid_q;
	assign token = token_q;
	assign data  = data_q;
	assign hit   = token_q & valid_q & (data_q == term);

endmodule

>>> hw/rtl/byte_ring_fifo_line_reader.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_line_reader
// byte fifo with push, read, read-line and flush actions, built as a
// shifting chain of byte cells
// ----------------------------------------------------------------------------
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser: action; tdata: data_in, request_count
// m_*       out  m_tvalid/m_tready   tuser: ok; tdata: data_out; tlast: last
// apb       in   psel/penable/pready register 0 terminator_byte at address 0
//
// one item is handled at a time; push, flush and failed reads give a single result
// a read of n bytes pops them from the head cell, one byte per cycle while m_tready allows
// read-line first scans as a token walks the cell chain up to the terminator,
// or over min(stored, request_count) bytes when no terminator turns up
// a stalled m_tready holds the output register and the engine before its next result
// arst_n clears the cells' valid bits and the counters, no clearing pass
//
module byte_ring_fifo_line_reader #(
	parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_in, [15:8] request_count
	input  logic [1:0]  s_tuser,   // [1:0] action
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data_out
	output logic [0:0]  m_tuser,   // [0] ok
	output logic        m_tlast,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "byte_ring_fifo_line_reader_defines.svh"

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = brf_pkg::REQ_W + 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	// engine states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	// configuration
	logic [brf_pkg::DATA_W-1:0] term_q;
	logic                       cfg_wr;

	// engine registers
	logic [1:0]                state_q, state_d;
	logic [CNT_W-1:0]          cnt_q, cnt_d;     // bytes held
	logic [CNT_W-1:0]          rem_q, rem_d;     // bytes still to emit
	logic [CNT_W-1:0]          idx_q, idx_d;     // scan offset
	logic [CNT_W-1:0]          span_q, span_d;   // scan length
	logic [brf_pkg::REQ_W-1:0] req_q, req_d;
	logic                      resp_ok_q, resp_ok_d;

	// output register
	logic                       out_valid_q;
	logic                       out_ok_q, out_last_q;
	logic [brf_pkg::DATA_W-1:0] out_data_q;
	logic                       out_load, out_ok_d, out_last_d;
	logic [brf_pkg::DATA_W-1:0] out_data_d;
	logic                       can_load;

	// chain wiring
	brf_pkg::cell_ctrl_t        ctrl;
	logic [DEPTH:0]             vq;          // cell valid bits, top one tied low
	logic [DEPTH-1:0]           pv;          // valid of the cell ahead
	logic [DEPTH-1:0]           tq;          // scan tokens
	logic [DEPTH-1:0]           ptok;
	logic [DEPTH-1:0]           head_v;
	logic [DEPTH-1:0]           hit_w;
	logic [brf_pkg::DATA_W-1:0] dq [DEPTH+1];
	logic                       hit_any;

	// input decode
	logic                       in_fire;
	logic [1:0]                 action;
	logic [brf_pkg::REQ_W-1:0]  req_in;
	logic [CNT_W-1:0]           avail;       // min(cnt, request_count)
	logic [CNT_W-1:0]           idx_inc;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == brf_pkg::REG_TERM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= brf_pkg::TERM_RESET;
		end else if (cfg_wr) begin
			term_q <= pwdata[brf_pkg::DATA_W-1:0];
		end
	end

	assign prdata = (paddr[2] == brf_pkg::REG_TERM) ? {24'd0, term_q} : 32'd0;

	// ------------------------------------------------------------------
	// cell chain: cell 0 is the oldest byte, pops shift toward it
	// ------------------------------------------------------------------
	assign vq[DEPTH]  = 1'b0;
	assign dq[DEPTH]  = '0;
	assign pv         = {vq[DEPTH-2:0], 1'b1};
	assign ptok       = {tq[DEPTH-2:0], 1'b0};
	assign head_v     = DEPTH'(1);
	assign hit_any    = |hit_w;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		brf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.byte_in    (s_tdata[7:0]),
			.term       (term_q),
			.head       (head_v[i]),
			.prev_valid (pv[i]),
			.prev_token (ptok[i]),
			.next_valid (vq[i+1]),
			.next_data  (dq[i+1]),
			.valid      (vq[i]),
			.token      (tq[i]),
			.hit        (hit_w[i]),
			.data       (dq[i])
		);
	end

	// ------------------------------------------------------------------
	// engine
	// ------------------------------------------------------------------
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid & s_tready;
	assign action   = s_tuser;
	assign req_in   = s_tdata[15:8];
	assign avail    = (CMP_W'(cnt_q) < CMP_W'(req_in)) ? cnt_q : CNT_W'(req_in);
	assign idx_inc  = idx_q + ONE_C;
	assign can_load = ~out_valid_q | m_tready;

	always_comb begin
		ctrl       = '0;
		state_d    = state_q;
		cnt_d      = cnt_q;
		rem_d      = rem_q;
		idx_d      = idx_q;
		span_d     = span_q;
		req_d      = req_q;
		resp_ok_d  = resp_ok_q;
		out_load   = 1'b0;
		out_ok_d   = 1'b0;
		out_data_d = '0;
		out_last_d = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (action)
						brf_pkg::ACT_PUSH: begin
							// a full fifo drops the byte
							if (cnt_q < DEPTH_C) begin
								ctrl.push = 1'b1;
								cnt_d     = cnt_q + ONE_C;
								resp_ok_d = 1'b1;
							end else begin
								resp_ok_d = 1'b0;
							end
							state_d = ST_RESP;
						end
						brf_pkg::ACT_READ: begin
							if (avail == '0) begin
								resp_ok_d = 1'b0;
								state_d   = ST_RESP;
							end else begin
								rem_d   = avail;
								state_d = ST_POP;
							end
						end
						brf_pkg::ACT_LINE: begin
							if (avail == '0) begin
								resp_ok_d = 1'b0;
								state_d   = ST_RESP;
							end else begin
								ctrl.scan_start = 1'b1;
								idx_d           = '0;
								span_d          = avail;
								req_d           = req_in;
								state_d         = ST_SCAN;
							end
						end
						brf_pkg::ACT_FLUSH: begin
							ctrl.flush = 1'b1;
							cnt_d      = '0;
							resp_ok_d  = 1'b1;
							state_d    = ST_RESP;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (hit_any) begin
					// the line must leave at least one byte of the request unused
					if (CMP_W'(idx_inc) < CMP_W'(req_q)) begin
						rem_d   = idx_inc;
						state_d = ST_POP;
					end else begin
						resp_ok_d = 1'b0;
						state_d   = ST_RESP;
					end
				end else if (idx_inc == span_q) begin
					resp_ok_d = 1'b0;
					state_d   = ST_RESP;
				end else begin
					ctrl.scan_step = 1'b1;
					idx_d          = idx_inc;
				end
			end
			ST_POP: begin
				if (can_load) begin
					ctrl.pop   = 1'b1;
					out_load   = 1'b1;
					out_ok_d   = 1'b1;
					out_data_d = dq[0];
					out_last_d = (rem_q == ONE_C);
					cnt_d      = cnt_q - ONE_C;
					rem_d      = rem_q - ONE_C;
					if (rem_q == ONE_C) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_RESP: begin
				if (can_load) begin
					out_load   = 1'b1;
					out_ok_d   = resp_ok_q;
					out_last_d = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			idx_q       <= '0;
			span_q      <= '0;
			req_q       <= '0;
			resp_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			rem_q     <= rem_d;
			idx_q     <= idx_d;
			span_q    <= span_d;
			req_q     <= req_d;
			resp_ok_q <= resp_ok_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q   <= out_ok_d;
			out_data_q <= out_data_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tuser[0] = out_ok_q;
	assign m_tdata    = out_data_q;
	assign m_tlast    = out_last_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`BRF_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= DEPTH_C, "byte count above depth")
	`BRF_ASSERT(a_cnt_matches_cells, clk, arst_n, $countones(vq) == int'(cnt_q), "count and cell valid bits disagree")
	`BRF_ASSERT_IMP(a_scan_token, clk, arst_n, state_q == ST_SCAN, $onehot0(tq), "more than one scan token")
	`BRF_ASSERT_IMP(a_pop_nonzero, clk, arst_n, state_q == ST_POP, rem_q != '0 && rem_q <= cnt_q, "pop run exceeds stored bytes")
	`BRF_ASSERT_NXT(a_full_push, clk, arst_n, in_fire && action == brf_pkg::ACT_PUSH && cnt_q == DEPTH_C, cnt_q == DEPTH_C && state_q == ST_RESP && !resp_ok_q, "push into full fifo changed state")

endmodule
